### sv/ccpr_pkg.sv
// Shared types and codes for the congestion class path ranker.
// No dependencies; imported by the ranker core and its checker.
`default_nettype none

package ccpr_pkg;

    // Raw Q4.12 value taken as 0.6
    localparam logic [15:0] UTIL_LIMIT = 16'd2458;
    localparam logic [3:0]  MAX_OUT    = 4'd8;

    typedef enum logic [2:0] {
        ST_RANKED  = 3'd0,
        ST_OVERWR  = 3'd1,
        ST_INSERT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CLS_CLEAR = 2'd0,
        CLS_UNDET = 2'd1,
        CLS_CONG  = 2'd2
    } t_cls;

    typedef enum logic {
        CFG_RTT_LOW = 1'b0,
        CFG_MAX_SEL = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOAD  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    typedef struct packed {
        logic [31:0] path;
        logic [31:0] delay;
        logic [15:0] util;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

### sv/ccpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ccpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/congestion_class_path_ranker.sv
// Update: one status result after a scan of the destination's entries. Select: one
// ranked result after each scan, the best entry not yet emitted each time. One request
// at a time; busy stays high until the last result is on the ports. A destination out
// of range answers in the next cycle. The entry scan reads the table RAM one entry a
// cycle through one compare unit. After reset a clearing pass over the DESTS rows
// empties the valid rows while busy is high. Results cannot be stalled.
`default_nettype none

module congestion_class_path_ranker
    import ccpr_pkg::*;
#(
    parameter int DESTS = 16,
    parameter int PATHS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_action,
    input  wire logic [3:0]  i_dest_id,
    input  wire logic [31:0] i_path_id,
    input  wire logic [31:0] i_delay_ns,
    input  wire logic [15:0] i_utilization,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [31:0]      o_chosen_path,
    output logic [1:0]       o_path_class,
    output logic [2:0]       o_rank,
    output logic             o_last
);

    localparam int PW     = (PATHS > 1) ? $clog2(PATHS) : 1;
    localparam int DW     = $clog2(DESTS);
    localparam int EDEPTH = DESTS << PW;
    localparam logic [PW-1:0] LAST_IDX  = PW'(PATHS - 1);
    localparam logic [DW-1:0] LAST_DEST = DW'(DESTS - 1);

    function automatic t_cls cls_of(input logic [31:0] delay, input logic [15:0] util,
                                    input logic [31:0] rtt);
        t_cls c;
        if (rtt > delay) begin
            c = CLS_CLEAR;
        end else if (util < UTIL_LIMIT) begin
            c = CLS_UNDET;
        end else begin
            c = CLS_CONG;
        end
        return c;
    endfunction

    // true if candidate ranks ahead of the current best
    function automatic logic ranks_before(input t_cls ca, input t_entry a,
                                          input t_cls cb, input t_entry b);
        logic r;
        if (ca != cb) begin
            r = (ca < cb);
        end else if (ca == CLS_UNDET && a.util != b.util) begin
            r = (a.util > b.util);
        end else if (ca != CLS_UNDET && a.delay != b.delay) begin
            r = (a.delay < b.delay);
        end else begin
            r = (a.path < b.path);
        end
        return r;
    endfunction

    t_state r_state, n_state;

    logic [31:0]   r_rtt_low;
    logic [3:0]    r_max_sel;
    logic [DW-1:0] r_clr_idx;
    logic          r_issue;
    logic          r_ev;
    logic          r_out_vld;

    logic          r_action;
    logic [DW-1:0] r_dest;
    t_entry        r_req;
    logic [PATHS-1:0] r_row;
    logic [PATHS-1:0] r_taken;
    logic [PW-1:0] r_rd_idx;
    logic [PW-1:0] r_ev_idx;
    logic          r_hit;
    logic [PW-1:0] r_hit_idx;
    logic          r_free_f;
    logic [PW-1:0] r_free_idx;
    logic          r_best_f;
    t_entry        r_best;
    t_cls          r_b_cls;
    logic [PW-1:0] r_b_idx;
    logic [1:0]    r_cnt;
    logic [2:0]    r_k;

    logic [2:0]    r_o_status;
    logic [31:0]   r_o_path;
    logic [1:0]    r_o_cls;
    logic [2:0]    r_o_rank;
    logic          r_o_last;

    logic [PATHS-1:0] row_rdata, row_wdata;
    logic [DW-1:0]    row_waddr;
    logic             row_we;
    logic [ENTRY_W-1:0] ent_rdata_raw;
    t_entry           ent;
    logic             ent_we;
    logic [PW-1:0]    ent_widx;

    logic        accept, in_range;
    logic        ev_cand, pass_end;
    t_cls        ev_cls;
    logic [3:0]  lim;
    logic        sel_last;
    logic        emit;
    t_status     e_status;
    logic [31:0] e_path;
    t_cls        e_cls;
    logic [2:0]  e_rank;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && (r_state == S_IDLE);
    assign in_range = ({28'd0, i_dest_id} < 32'(DESTS));

    assign ent      = t_entry'(ent_rdata_raw);
    assign ev_cand  = r_row[r_ev_idx] && !r_taken[r_ev_idx];
    assign ev_cls   = cls_of(ent.delay, ent.util, r_rtt_low);
    assign pass_end = r_ev && (r_ev_idx == LAST_IDX);

    always_comb begin
        priority if (r_max_sel == 4'd0) begin
            lim = 4'd1;
        end else if (r_max_sel > MAX_OUT) begin
            lim = MAX_OUT;
        end else begin
            lim = r_max_sel;
        end
    end

    assign sel_last = (({1'b0, r_k} + 4'd1) == lim) || (r_cnt == 2'd1);

    // Result selection
    always_comb begin
        emit     = 1'b0;
        e_status = ST_RANKED;
        e_path   = 32'd0;
        e_cls    = CLS_CLEAR;
        e_rank   = 3'd0;
        if (accept && !in_range) begin
            emit     = 1'b1;
            e_status = i_action ? ST_NONE : ST_FULL;
        end else if (r_state == S_FIN) begin
            emit = 1'b1;
            if (!r_action) begin
                priority if (r_hit) begin
                    e_status = ST_OVERWR;
                end else if (r_free_f) begin
                    e_status = ST_INSERT;
                end else begin
                    e_status = ST_FULL;
                end
            end else if (r_cnt == 2'd0) begin
                e_status = ST_NONE;
            end else begin
                e_status = ST_RANKED;
                e_path   = r_best.path;
                e_cls    = r_b_cls;
                e_rank   = r_k;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == LAST_DEST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && in_range) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_SCAN;
            S_SCAN: begin
                if (pass_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (r_action && r_cnt != 2'd0 && !sel_last) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM ports
    assign ent_widx  = r_hit ? r_hit_idx : r_free_idx;
    assign ent_we    = (r_state == S_FIN) && !r_action && (r_hit || r_free_f);
    assign row_we    = (r_state == S_CLEAR) ||
                       ((r_state == S_FIN) && !r_action && !r_hit && r_free_f);
    assign row_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_dest;
    assign row_wdata = (r_state == S_CLEAR) ? '0 : (r_row | (PATHS'(1) << r_free_idx));

    ccpr_ram #(
        .WIDTH (PATHS),
        .DEPTH (DESTS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (DW'(i_dest_id)),
        .o_rdata (row_rdata)
    );

    ccpr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (EDEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr ({r_dest, ent_widx}),
        .i_wdata (r_req),
        .i_raddr ({r_dest, r_rd_idx}),
        .o_rdata (ent_rdata_raw)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_rtt_low <= 32'd5408;
            r_max_sel <= 4'd4;
            r_clr_idx <= '0;
            r_issue   <= 1'b0;
            r_ev      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= emit;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_RTT_LOW: r_rtt_low <= i_cfg_wdata;
                    CFG_MAX_SEL: r_max_sel <= i_cfg_wdata[3:0];
                    default:     r_rtt_low <= r_rtt_low;
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + DW'(1);
            end
            // issue one entry read a cycle; its data is checked in the next cycle
            r_ev <= r_issue;
            if (r_state == S_LOAD ||
                (r_state == S_FIN && n_state == S_SCAN)) begin
                r_issue <= 1'b1;
            end else if (r_issue && r_rd_idx == LAST_IDX) begin
                r_issue <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_o_status <= e_status;
        r_o_path   <= e_path;
        r_o_cls    <= e_cls;
        r_o_rank   <= e_rank;
        r_o_last   <= !(e_status == ST_RANKED) || sel_last;

        if (accept) begin
            r_action   <= i_action;
            r_dest     <= DW'(i_dest_id);
            r_req.path  <= i_path_id;
            r_req.delay <= i_delay_ns;
            r_req.util  <= i_utilization;
        end

        if (r_state == S_LOAD) begin
            r_row   <= row_rdata;
            r_taken <= '0;
            r_k     <= 3'd0;
        end

        if (r_state == S_LOAD || r_state == S_FIN) begin
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
            r_free_f <= 1'b0;
            r_best_f <= 1'b0;
            r_cnt    <= 2'd0;
        end else if (r_issue && r_rd_idx != LAST_IDX) begin
            r_rd_idx <= r_rd_idx + PW'(1);
        end
        r_ev_idx <= r_rd_idx;

        if (r_state == S_SCAN && r_ev) begin
            if (!r_action) begin
                if (ev_cand && ent.path == r_req.path) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_ev_idx;
                end
                if (!r_row[r_ev_idx] && !r_free_f) begin
                    r_free_f   <= 1'b1;
                    r_free_idx <= r_ev_idx;
                end
            end else if (ev_cand) begin
                if (r_cnt != 2'd2) begin
                    r_cnt <= r_cnt + 2'd1;
                end
                if (!r_best_f || ranks_before(ev_cls, ent, r_b_cls, r_best)) begin
                    r_best_f <= 1'b1;
                    r_best   <= ent;
                    r_b_cls  <= ev_cls;
                    r_b_idx  <= r_ev_idx;
                end
            end
        end

        // mark the emitted path and advance the rank
        if (r_state == S_FIN && r_action && r_cnt != 2'd0) begin
            r_taken[r_b_idx] <= 1'b1;
            r_k              <= r_k + 3'd1;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_status      = r_o_status;
    assign o_chosen_path = r_o_path;
    assign o_path_class  = r_o_cls;
    assign o_rank        = r_o_rank;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire

### sv/ccpr_checker.sv
// Port-level checker for the congestion class path ranker, bound to the top level.
// Depends on ccpr_pkg for the status and class codes.
`default_nettype none

module ccpr_checker
    import ccpr_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_valid,
    input wire logic [2:0]  o_status,
    input wire logic [31:0] o_chosen_path,
    input wire logic [1:0]  o_path_class,
    input wire logic [2:0]  o_rank,
    input wire logic        o_last
);

    // a non-ranked status closes the request
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_RANKED |-> o_last)
        else $error("non-ranked result without last");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_RANKED |->
            o_chosen_path == 32'd0 && o_path_class == CLS_CLEAR && o_rank == 3'd0)
        else $error("non-ranked result carries path fields");

    // an accepted request either answers at once or holds busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid)
        else $error("request accepted but neither busy nor answered");

    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("more results due while idle");

endmodule

bind congestion_class_path_ranker ccpr_checker u_ccpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_chosen_path (o_chosen_path),
    .o_path_class  (o_path_class),
    .o_rank        (o_rank),
    .o_last        (o_last)
);

`default_nettype wire
